@@ hdl/wma_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average package
// Shared sizes, derived widths and the job record passed from front to back.
// ----------------------------------------------------------------------------
package wma_pkg;

  localparam int WINDOW   = 100;
  localparam int SMP_W    = 16;
  localparam int FILL_W   = 7;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W    = CNT_W + SMP_W;
  localparam int MAG_W    = SUM_W - 1;
  localparam int DIV_ITER = (MAG_W + 1) / 2;
  localparam int DVD_W    = 2 * DIV_ITER;
  localparam int ITER_W   = $clog2(DIV_ITER + 1);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QLVL_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } job_t;

endpackage

@@ hdl/windowed_moving_average_core.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average core
// Running mean of the last WINDOW signed Q8.8 readings.
// ----------------------------------------------------------------------------
// Use:
//   Input side is a queue write port: drive in_sample and raise push; the
//   reading is taken at a clock edge where push is high and full is low.
//   Result side is a queue read port: while empty is low, out_last_sample,
//   out_window_average and out_fill_count show the oldest waiting item;
//   raise pop to take it.
//   Each reading gives one item: the reading itself, the sum of held readings
//   divided by the fill count (truncated toward zero) and the fill count.
// Timing:
//   The front end reads the ring slot, then updates the sum, for each reading.
//   The divider resolves two quotient bits a cycle, and the back end takes
//   a new job from the queue only once it is done with the last one.
//   That divider loop sets the sustained rate. With the divider idle, an
//   accepted reading passes sum update, queue, divider load, iterations and done.
// Reset and stalls:
//   Reset empties the window, sum, job queue and output register. The ring
//   contents are not cleared. Full goes high at every accept and stays high
//   while the reading is folded in. A stalled receiver holds the output
//   register; the divider then waits with its finished item, the two-entry
//   job queue fills and the front end holds its reading, keeping full high.
// ----------------------------------------------------------------------------
module windowed_moving_average_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [wma_pkg::SMP_W-1:0]  in_sample,
  output logic                       empty,
  input  logic                       pop,
  output logic [wma_pkg::SMP_W-1:0]  out_last_sample,
  output logic [wma_pkg::SMP_W-1:0]  out_window_average,
  output logic [wma_pkg::FILL_W-1:0] out_fill_count
);

  // Jobs travel from the ring/sum front end to the divider through the queue.
  wma_pkg::job_t fq_job, qb_job;
  logic          fq_push, fq_full;
  logic          qb_rd, qb_empty;

  // Fold each reading into the ring and running sum.
  wma_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_sample (in_sample),
    .job_push  (fq_push),
    .job_full  (fq_full),
    .job       (fq_job)
  );

  // Buffer jobs so the front end keeps going while the divider works.
  wma_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fq_push),
    .q_full  (fq_full),
    .wr_job  (fq_job),
    .rd      (qb_rd),
    .q_empty (qb_empty),
    .rd_job  (qb_job)
  );

  // Divide and present the item.
  wma_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (qb_empty),
    .q_rd               (qb_rd),
    .job                (qb_job),
    .empty              (empty),
    .pop                (pop),
    .out_last_sample    (out_last_sample),
    .out_window_average (out_window_average),
    .out_fill_count     (out_fill_count)
  );

  // Front end never writes into a full job queue.
  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push |-> !fq_full)
    else $error("job queue written while full");

  // Every job carries a fill count within the window.
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push |-> (fq_job.count != '0) &&
                (fq_job.count <= wma_pkg::CNT_W'(wma_pkg::WINDOW)))
    else $error("job fill count out of range");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result pending after reset");

  // Divider only pulls a job that is there.
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    qb_rd |-> !qb_empty)
    else $error("divider read an empty job queue");

endmodule

@@ hdl/wma_front.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average front end
// Accepts readings, keeps the sample ring, running sum and fill count.
// ----------------------------------------------------------------------------
module wma_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [wma_pkg::SMP_W-1:0] in_sample,
  output logic                job_push,
  input  logic                job_full,
  output wma_pkg::job_t       job
);

  localparam logic FS_IDLE   = 1'b0;
  localparam logic FS_UPDATE = 1'b1;

  logic                               state_r, state_nxt;
  logic [wma_pkg::PTR_W-1:0]          wp_r, wp_nxt;
  logic [wma_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [wma_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [wma_pkg::SMP_W-1:0]          smp_r;
  logic [wma_pkg::SMP_W-1:0]          rd_q;
  logic [wma_pkg::SMP_W-1:0]          ring_mem [wma_pkg::WINDOW];
  logic                               held_full;
  logic                               wr_en;
  logic signed [wma_pkg::SUM_W-1:0]   old_ext, new_ext;

  assign full      = (state_r != FS_IDLE);
  assign held_full = (cnt_r == wma_pkg::CNT_W'(wma_pkg::WINDOW));
  assign wr_en     = (state_r == FS_UPDATE) && !job_full;
  assign job_push  = wr_en;

  assign old_ext = held_full ?
    $signed({{(wma_pkg::SUM_W-wma_pkg::SMP_W){rd_q[wma_pkg::SMP_W-1]}}, rd_q}) : '0;
  assign new_ext =
    $signed({{(wma_pkg::SUM_W-wma_pkg::SMP_W){smp_r[wma_pkg::SMP_W-1]}}, smp_r});

  // Ring: read of the slot at the write pointer is registered every cycle.
  always_ff @(posedge clk) begin
    rd_q <= ring_mem[wp_r];
    if (wr_en) begin
      ring_mem[wp_r] <= smp_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    cnt_nxt   = held_full ? cnt_r : cnt_r + 1'b1;
    sum_nxt   = sum_r - old_ext + new_ext;
    case (state_r)
      FS_IDLE: begin
        if (push) begin
          state_nxt = FS_UPDATE;
        end
      end
      FS_UPDATE: begin
        if (!job_full) begin
          state_nxt = FS_IDLE;
          wp_nxt = (wp_r == wma_pkg::PTR_W'(wma_pkg::WINDOW - 1)) ? '0 : wp_r + 1'b1;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  assign job.sample = smp_r;
  assign job.sum    = sum_nxt;
  assign job.count  = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      wp_r    <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      if (wr_en) begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  // Hold the reading while it is folded into the window.
  always_ff @(posedge clk) begin
    if ((state_r == FS_IDLE) && push) begin
      smp_r <= in_sample;
    end
  end

endmodule

@@ hdl/wma_queue.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average job queue
// Short queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module wma_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  output logic          q_full,
  input  wma_pkg::job_t wr_job,
  input  logic          rd,
  output logic          q_empty,
  output wma_pkg::job_t rd_job
);

  wma_pkg::job_t                 entry_r [wma_pkg::QDEPTH];
  logic [wma_pkg::QPTR_W-1:0]    wptr_r, rptr_r;
  logic [wma_pkg::QLVL_W-1:0]    lvl_r;
  logic                          do_wr, do_rd;

  assign q_full  = (lvl_r == wma_pkg::QLVL_W'(wma_pkg::QDEPTH));
  assign q_empty = (lvl_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      lvl_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + 1'b1;
      if (do_rd) rptr_r <= rptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        lvl_r <= lvl_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        lvl_r <= lvl_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/wma_back.sv @@
// ----------------------------------------------------------------------------
// Windowed moving average back end
// Divides the running sum by the fill count, two quotient bits a cycle,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module wma_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_rd,
  input  wma_pkg::job_t              job,
  output logic                       empty,
  input  logic                       pop,
  output logic [wma_pkg::SMP_W-1:0]  out_last_sample,
  output logic [wma_pkg::SMP_W-1:0]  out_window_average,
  output logic [wma_pkg::FILL_W-1:0] out_fill_count
);

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_DIV  = 2'd1;
  localparam logic [1:0] BS_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [wma_pkg::ITER_W-1:0]   it_r;
  logic [wma_pkg::DVD_W-1:0]    dvd_r, quo_r;
  logic [wma_pkg::CNT_W-1:0]    div_r, rem_r;
  logic                         neg_r;
  logic [wma_pkg::SMP_W-1:0]    smp_r;
  logic                         oval_r;
  logic [wma_pkg::SMP_W-1:0]    olast_r, oavg_r;
  logic [wma_pkg::FILL_W-1:0]   ofill_r;

  logic [wma_pkg::CNT_W:0]      r1, r2, s1, s2, dext;
  logic [wma_pkg::CNT_W-1:0]    rem1, rem2;
  logic                         ge1, ge2;
  logic [wma_pkg::SUM_W-1:0]    abs_sum;
  logic [wma_pkg::SMP_W-1:0]    q16, avg;
  logic                         slot_free;

  assign q_rd      = (state_r == BS_IDLE) && !q_empty;
  assign slot_free = !oval_r || pop;

  // Two restoring steps per cycle.
  assign dext = {1'b0, div_r};
  assign r1   = {rem_r, dvd_r[wma_pkg::DVD_W-1]};
  assign ge1  = (r1 >= dext);
  assign s1   = ge1 ? r1 - dext : r1;
  assign rem1 = s1[wma_pkg::CNT_W-1:0];
  assign r2   = {rem1, dvd_r[wma_pkg::DVD_W-2]};
  assign ge2  = (r2 >= dext);
  assign s2   = ge2 ? r2 - dext : r2;
  assign rem2 = s2[wma_pkg::CNT_W-1:0];

  assign abs_sum = job.sum[wma_pkg::SUM_W-1] ? -job.sum : job.sum;
  assign q16     = quo_r[wma_pkg::SMP_W-1:0];
  assign avg     = neg_r ? (~q16 + 1'b1) : q16;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) state_nxt = BS_DIV;
      end
      BS_DIV: begin
        if (it_r == wma_pkg::ITER_W'(wma_pkg::DIV_ITER - 1)) state_nxt = BS_DONE;
      end
      BS_DONE: begin
        if (slot_free) state_nxt = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == BS_DONE) && slot_free) begin
        oval_r <= 1'b1;
      end else if (pop) begin
        oval_r <= 1'b0;
      end
    end
  end

  // Divider datapath and output register.
  always_ff @(posedge clk) begin
    case (state_r)
      BS_IDLE: begin
        dvd_r <= wma_pkg::DVD_W'(abs_sum[wma_pkg::MAG_W-1:0]);
        quo_r <= '0;
        rem_r <= '0;
        div_r <= job.count;
        neg_r <= job.sum[wma_pkg::SUM_W-1];
        smp_r <= job.sample;
        it_r  <= '0;
      end
      BS_DIV: begin
        dvd_r <= {dvd_r[wma_pkg::DVD_W-3:0], 2'b00};
        quo_r <= {quo_r[wma_pkg::DVD_W-3:0], ge1, ge2};
        rem_r <= rem2;
        it_r  <= it_r + 1'b1;
      end
      BS_DONE: begin
        if (slot_free) begin
          olast_r <= smp_r;
          oavg_r  <= avg;
          ofill_r <= div_r[wma_pkg::FILL_W-1:0];
        end
      end
      default: begin
        it_r <= '0;
      end
    endcase
  end

  assign empty              = !oval_r;
  assign out_last_sample    = olast_r;
  assign out_window_average = oavg_r;
  assign out_fill_count     = ofill_r;

endmodule
